// File: sv/phc_pkg.sv
// Shared constants for the packet header checker.
// Field widths, header layout, marker bytes, register indexes and error bit positions.
// No dependencies.
package phc_pkg;

	localparam int HDR_BYTES = 16;
	localparam int IDX_W     = $clog2(HDR_BYTES);
	localparam int CFG_IDX_W = 8;
	localparam int ERR_W     = 7;

	typedef logic [7:0]       byte_t;
	typedef logic [31:0]      word_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [ERR_W-1:0] err_t;

	// header layout
	localparam idx_t IDX_ID      = idx_t'(4);
	localparam idx_t IDX_SOURCE  = idx_t'(5);
	localparam idx_t IDX_FLAGS   = idx_t'(7);
	localparam idx_t IDX_PLEN_LO = idx_t'(8);
	localparam idx_t IDX_BCNT_LO = idx_t'(12);
	localparam idx_t IDX_LAST    = idx_t'(HDR_BYTES - 1);

	// start marker "$PKT"
	localparam byte_t MARKER [4] = '{8'h24, 8'h50, 8'h4B, 8'h54};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PID_PACKET_LIMIT  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PID_FIRE_LAYER    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PID_STREAM_LIMIT  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_ONBOARD_LIMIT = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_SERVER_BASE   = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_REMOTE_LIMIT  = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_FLAGS_MASK  = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD_LEN   = 8'd7;

	// configuration reset values
	localparam byte_t RST_PID_PACKET_LIMIT  = 8'd32;
	localparam byte_t RST_PID_FIRE_LAYER    = 8'd128;
	localparam byte_t RST_PID_STREAM_LIMIT  = 8'd192;
	localparam byte_t RST_SRC_ONBOARD_LIMIT = 8'd16;
	localparam byte_t RST_SRC_SERVER_BASE   = 8'd128;
	localparam byte_t RST_SRC_REMOTE_LIMIT  = 8'd192;
	localparam byte_t RST_VALID_FLAGS_MASK  = 8'hFF;
	localparam word_t RST_MAX_PAYLOAD_LEN   = 32'd65536;

	// error bit positions
	localparam int ERR_MARKER  = 0;
	localparam int ERR_ID      = 1;
	localparam int ERR_SOURCE  = 2;
	localparam int ERR_LRC     = 3;
	localparam int ERR_FLAGS   = 4;
	localparam int ERR_PAYLOAD = 5;
	localparam int ERR_LENGTH  = 6;

endpackage

// File: sv/phc_if.sv
// Handshake channels of the packet header checker: header bytes, results, config writes.
// Depends on phc_pkg.
interface phc_in_if;
	import phc_pkg::*;
	logic  valid;
	logic  ready;
	byte_t header_byte;
	logic  first_byte;
	word_t received_length;

	modport source (output valid, header_byte, first_byte, received_length, input ready);
	modport sink   (input valid, header_byte, first_byte, received_length, output ready);
endinterface

interface phc_out_if;
	import phc_pkg::*;
	logic  valid;
	logic  ready;
	logic  header_ok;
	err_t  error_bits;
	byte_t packet_id;
	byte_t source_id;
	byte_t flag_bits;
	word_t payload_len;
	word_t block_count;

	modport source (output valid, header_ok, error_bits, packet_id, source_id, flag_bits,
		payload_len, block_count, input ready);
	modport sink   (input valid, header_ok, error_bits, packet_id, source_id, flag_bits,
		payload_len, block_count, output ready);
endinterface

interface phc_cfg_if;
	import phc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	word_t                wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: sv/packet_header_checker.sv
// Packet header checker top level: byte intake, field capture, header checks.
// Depends on phc_pkg and the channel interfaces in phc_if.sv.
//
// Usage:
//   hdr  - header beats, one byte each, in wire order: marker "$PKT", id,
//          source, LRC, flags, payload length (LE32), block count (LE32).
//          first_byte restarts the header at byte 0 and drops a partial one.
//          received_length is used on the last byte only.
//   res  - one result beat per complete 16-byte header: pass flag, error
//          bits and the captured fields.
//   cfg  - register writes, always ready; write only while the block is idle.
// Timing: one byte per cycle sustained while the result slot is free. A byte
// lands in the input register at acceptance and is folded into the running
// sum and captures on the next edge, a final byte only with the slot free;
// its result enters the output register on that edge. The output register is
// the only result buffer: while the receiver stalls, non-final bytes keep
// flowing and a final byte waits in the input register until the slot frees.
// Reset: byte index and running sum cleared, marker match set, registers
// back to their defaults, channels empty.
module packet_header_checker (
	input  logic            clk,
	input  logic            arst_n,
	phc_in_if.sink          hdr,
	phc_out_if.source       res,
	phc_cfg_if.sink         cfg
);
	import phc_pkg::*;

	// configuration registers
	byte_t pid_packet_limit_q, pid_fire_layer_q, pid_stream_limit_q;
	byte_t src_onboard_limit_q, src_server_base_q, src_remote_limit_q;
	byte_t valid_flags_mask_q;
	word_t max_payload_len_q;

	// input register
	logic  valid_s1;
	byte_t byte_s1;
	logic  first_s1;
	word_t rx_len_s1;

	// header state
	idx_t  byte_index_q;
	byte_t running_sum_q;
	logic  marker_match_q;
	byte_t held_id_q, held_source_q, held_flags_q;
	word_t held_plen_q, held_bcnt_q;

	// result register
	logic  res_valid_q;
	logic  res_ok_q;
	err_t  res_err_q;
	byte_t res_id_q, res_src_q, res_flags_q;
	word_t res_plen_q, res_bcnt_q;

	idx_t  idx;
	logic  last;
	logic  res_free;
	logic  fire_s1;
	logic  in_take;
	byte_t sum_nx;
	err_t  err;

	// write configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_packet_limit_q  <= RST_PID_PACKET_LIMIT;
			pid_fire_layer_q    <= RST_PID_FIRE_LAYER;
			pid_stream_limit_q  <= RST_PID_STREAM_LIMIT;
			src_onboard_limit_q <= RST_SRC_ONBOARD_LIMIT;
			src_server_base_q   <= RST_SRC_SERVER_BASE;
			src_remote_limit_q  <= RST_SRC_REMOTE_LIMIT;
			valid_flags_mask_q  <= RST_VALID_FLAGS_MASK;
			max_payload_len_q   <= RST_MAX_PAYLOAD_LEN;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_PID_PACKET_LIMIT:  pid_packet_limit_q  <= cfg.wdata[7:0];
				REG_PID_FIRE_LAYER:    pid_fire_layer_q    <= cfg.wdata[7:0];
				REG_PID_STREAM_LIMIT:  pid_stream_limit_q  <= cfg.wdata[7:0];
				REG_SRC_ONBOARD_LIMIT: src_onboard_limit_q <= cfg.wdata[7:0];
				REG_SRC_SERVER_BASE:   src_server_base_q   <= cfg.wdata[7:0];
				REG_SRC_REMOTE_LIMIT:  src_remote_limit_q  <= cfg.wdata[7:0];
				REG_VALID_FLAGS_MASK:  valid_flags_mask_q  <= cfg.wdata[7:0];
				REG_MAX_PAYLOAD_LEN:   max_payload_len_q   <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// position of the byte in the input register; a final byte needs the result slot
	assign idx      = first_s1 ? '0 : byte_index_q;
	assign last     = (idx == IDX_LAST);
	assign res_free = !res_valid_q || res.ready;
	assign fire_s1  = valid_s1 && (!last || res_free);
	assign hdr.ready = !valid_s1 || fire_s1;
	assign in_take  = hdr.valid && hdr.ready;

	// hold a beat in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1   <= hdr.header_byte;
			first_s1  <= hdr.first_byte;
			rx_len_s1 <= hdr.received_length;
		end
	end

	assign sum_nx = (idx == '0) ? byte_s1 : byte_t'(running_sum_q + byte_s1);

	// header checks: captured fields, the sum with the current byte, its received length
	always_comb begin
		err = '0;
		err[ERR_MARKER] = !marker_match_q;
		err[ERR_ID]     = (held_id_q >= pid_packet_limit_q && held_id_q < pid_fire_layer_q)
			|| held_id_q >= pid_stream_limit_q;
		err[ERR_SOURCE] = (held_source_q >= src_onboard_limit_q
			&& held_source_q < src_server_base_q) || held_source_q >= src_remote_limit_q;
		err[ERR_LRC]    = (sum_nx != 8'hFF);
		err[ERR_FLAGS]  = (held_flags_q & ~valid_flags_mask_q) != 8'h00;
		err[ERR_PAYLOAD] = (held_id_q <= pid_packet_limit_q)
			&& (held_plen_q > max_payload_len_q);
		err[ERR_LENGTH] = ({1'b0, held_plen_q} + 33'(HDR_BYTES)) != {1'b0, rx_len_s1};
	end

	// advance or restart index, sum and marker match; capture fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= '0;
			running_sum_q  <= '0;
			marker_match_q <= 1'b1;
			held_id_q      <= '0;
			held_source_q  <= '0;
			held_flags_q   <= '0;
			held_plen_q    <= '0;
			held_bcnt_q    <= '0;
		end else if (fire_s1) begin
			if (last) begin
				byte_index_q   <= '0;
				running_sum_q  <= '0;
				marker_match_q <= 1'b1;
			end else begin
				byte_index_q  <= idx_t'(idx + idx_t'(1));
				running_sum_q <= sum_nx;
				if (idx == '0) begin
					marker_match_q <= (byte_s1 == MARKER[0]);
				end else if (idx < IDX_ID) begin
					marker_match_q <= marker_match_q && (byte_s1 == MARKER[idx[1:0]]);
				end
			end
			// capture fields by position
			if (idx == IDX_ID) begin
				held_id_q <= byte_s1;
			end
			if (idx == IDX_SOURCE) begin
				held_source_q <= byte_s1;
			end
			if (idx == IDX_FLAGS) begin
				held_flags_q <= byte_s1;
			end
			if (idx[3:2] == IDX_PLEN_LO[3:2]) begin
				held_plen_q[idx[1:0]*8 +: 8] <= byte_s1;
			end
			if (idx[3:2] == IDX_BCNT_LO[3:2]) begin
				held_bcnt_q[idx[1:0]*8 +: 8] <= byte_s1;
			end
		end
	end

	// result register: load on the final byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && last) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last) begin
			res_ok_q    <= (err == '0);
			res_err_q   <= err;
			res_id_q    <= held_id_q;
			res_src_q   <= held_source_q;
			res_flags_q <= held_flags_q;
			res_plen_q  <= held_plen_q;
			res_bcnt_q  <= {byte_s1, held_bcnt_q[23:0]};
		end
	end

	assign res.valid       = res_valid_q;
	assign res.header_ok   = res_ok_q;
	assign res.error_bits  = res_err_q;
	assign res.packet_id   = res_id_q;
	assign res.source_id   = res_src_q;
	assign res.flag_bits   = res_flags_q;
	assign res.payload_len = res_plen_q;
	assign res.block_count = res_bcnt_q;

endmodule

// File: sv/phc_checker.sv
// Port-level checks for the packet header checker, bound to the top level.
// Depends on phc_pkg and packet_header_checker.
module phc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        hdr_valid,
	input logic                        hdr_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        res_header_ok,
	input logic [phc_pkg::ERR_W-1:0]   res_error_bits,
	input logic [31:0]                 res_payload_len,
	input logic [31:0]                 res_block_count
);
	import phc_pkg::*;

	// payload lengths at or above this cannot match any 32-bit received length
	localparam word_t PLEN_OVERFLOW = word_t'(33'h1_0000_0000 - 33'(HDR_BYTES));

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_error_bits)
			&& $stable(res_payload_len) && $stable(res_block_count))
		else $error("stalled result changed");

	// pass flag agrees with the error bits
	a_ok_bits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_header_ok == (res_error_bits == '0)))
		else $error("header_ok disagrees with error_bits");

	// a result into an empty slot follows a final byte accepted into the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(hdr_valid && hdr_ready, 2))
		else $error("result without a final byte");

	// an oversize payload is never zero; an overflowing length always fails
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_error_bits[ERR_PAYLOAD] |-> res_payload_len != '0)
		else $error("payload error on zero length");

	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_payload_len >= PLEN_OVERFLOW) |-> res_error_bits[ERR_LENGTH])
		else $error("overflowing length passed");

endmodule

bind packet_header_checker phc_checker u_phc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.hdr_valid       (hdr.valid),
	.hdr_ready       (hdr.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_header_ok   (res.header_ok),
	.res_error_bits  (res.error_bits),
	.res_payload_len (res.payload_len),
	.res_block_count (res.block_count)
);

// File: dv/testbench.sv
// Self-checking bench for packet_header_checker: directed header table, then random headers.
// Predicts each verdict from the accepted header beats and compares it on the result channel.
// Depends on phc_pkg, the channel interfaces in phc_if.sv and the packet_header_checker RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import phc_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int NUM_DIRECTED   = 17;
	localparam int NUM_PHASES     = 6;
	localparam int HDRS_PER_PHASE = 4;
	localparam int LRC_POS        = 6;

	localparam err_t E_NONE    = '0;
	localparam err_t E_MARKER  = err_t'(1 << ERR_MARKER);
	localparam err_t E_ID      = err_t'(1 << ERR_ID);
	localparam err_t E_SOURCE  = err_t'(1 << ERR_SOURCE);
	localparam err_t E_LRC     = err_t'(1 << ERR_LRC);
	localparam err_t E_FLAGS   = err_t'(1 << ERR_FLAGS);
	localparam err_t E_PAYLOAD = err_t'(1 << ERR_PAYLOAD);
	localparam err_t E_LENGTH  = err_t'(1 << ERR_LENGTH);

	typedef struct packed {
		byte_t pkt_limit;
		byte_t fire_layer;
		byte_t stream_limit;
		byte_t onboard_limit;
		byte_t server_base;
		byte_t remote_limit;
		byte_t flag_mask;
		word_t max_payload;
	} check_limits_t;

	typedef struct packed {
		logic  ok;
		err_t  err;
		byte_t id;
		byte_t src;
		byte_t flags;
		word_t plen;
		word_t bcnt;
	} header_result_t;

	// one header to send: fields, corruptions, how many bytes, optional fixed verdict
	typedef struct packed {
		byte_t      id;
		byte_t      src;
		byte_t      flags;
		word_t      plen;
		word_t      bcnt;
		word_t      rx_len;
		byte_t      lrc_skew;
		byte_t      marker_flip;
		logic [1:0] mark_pos;
		logic       first_mark;
		logic [4:0] n_bytes;
		logic       pinned;
		err_t       err;
	} hdr_plan_t;

	logic clk = 1'b0;
	logic arst_n;

	phc_in_if  hdr_ch ();
	phc_out_if res_ch ();
	phc_cfg_if cfg_ch ();

	packet_header_checker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #CLK_HALF clk = ~clk;

	// predictor state: register shadow, byte position, sum and captures
	check_limits_t lim = '{RST_PID_PACKET_LIMIT, RST_PID_FIRE_LAYER, RST_PID_STREAM_LIMIT,
		RST_SRC_ONBOARD_LIMIT, RST_SRC_SERVER_BASE, RST_SRC_REMOTE_LIMIT,
		RST_VALID_FLAGS_MASK, RST_MAX_PAYLOAD_LEN};
	idx_t  pos_now     = '0;
	byte_t lrc_sum     = '0;
	logic  marker_seen = 1'b1;
	byte_t cap_id      = '0;
	byte_t cap_src     = '0;
	byte_t cap_flags   = '0;
	word_t cap_plen    = '0;
	word_t cap_bcnt    = '0;

	header_result_t pending_verdicts [$];
	header_result_t want;
	int unsigned    mismatches   = 0;
	int unsigned    results_seen = 0;
	int unsigned    idle_cycles  = 0;
	bit             tx_idle      = 1'b1;
	bit             rx_idle      = 1'b1;

	// directed headers, all under reset limits
	hdr_plan_t directed_plan [NUM_DIRECTED] = '{
		// clean baseline
		'{8'h01, 8'h01, 8'h00, 32'h00000000, 32'h00000000, 32'h00000010,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_NONE},
		// low ids, all flags, payload at its limit, full block count
		'{8'h00, 8'h00, 8'hFF, 32'h00010000, 32'hFFFFFFFF, 32'h00010010,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_NONE},
		// top id, largest payload: the length sum must not wrap
		'{8'hFF, 8'hBF, 8'h5A, 32'hFFFFFFFF, 32'h00000000, 32'h0000000F,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_ID | E_LENGTH},
		// id at the packet limit: in the gap and still size checked
		'{8'h20, 8'h0F, 8'h00, 32'h00010001, 32'h12345678, 32'h00010011,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_ID | E_PAYLOAD},
		'{8'h7F, 8'h80, 8'h00, 32'h00000040, 32'hA5A5A5A5, 32'h00000050,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_ID},
		'{8'h80, 8'h10, 8'h00, 32'h00000000, 32'h00000000, 32'h00000010,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_SOURCE},
		'{8'hBF, 8'hC0, 8'h00, 32'h00000000, 32'h00000000, 32'h00000010,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_SOURCE},
		'{8'h1F, 8'h7F, 8'h00, 32'h00010001, 32'h00000001, 32'h00010011,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_SOURCE | E_PAYLOAD},
		'{8'h01, 8'h01, 8'h00, 32'h00000064, 32'h00000001, 32'h00000064,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_LENGTH},
		'{8'h01, 8'h01, 8'h00, 32'h00000000, 32'h00000000, 32'h00000010,
			8'h00, 8'h01, 2'd2, 1'b1, 5'd16, 1'b1, E_MARKER},
		'{8'h01, 8'h01, 8'h00, 32'h00000000, 32'h00000000, 32'h00000010,
			8'h01, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_LRC},
		// partial header, dropped by the restart below
		'{8'h99, 8'h66, 8'h33, 32'hCAFEF00D, 32'h0BADBEEF, 32'h00000000,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd9, 1'b0, E_NONE},
		'{8'h02, 8'h02, 8'h00, 32'h00000010, 32'h00000055, 32'h00000020,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_NONE},
		// no first mark: index wrapped to zero after the last header
		'{8'h03, 8'h03, 8'h00, 32'h00000000, 32'h00000000, 32'h00000010,
			8'h00, 8'h00, 2'd0, 1'b0, 5'd16, 1'b1, E_NONE},
		// stop one byte short, then restart on what would be the last byte
		'{8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd15, 1'b0, E_NONE},
		'{8'hC0, 8'hFF, 8'h00, 32'h00000000, 32'h00000000, 32'h00000000,
			8'h80, 8'hFF, 2'd0, 1'b1, 5'd16, 1'b1,
			E_MARKER | E_ID | E_SOURCE | E_LRC | E_LENGTH},
		'{8'h80, 8'h80, 8'h00, 32'hFFFFFFEF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			8'h00, 8'h00, 2'd0, 1'b1, 5'd16, 1'b1, E_NONE}
	};

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
				results_seen, name, got, exp_val));
	endtask

	// fold one accepted header beat into the predictor; 1 when it closes a header
	function automatic bit fold_header_byte(input byte_t b, input logic first,
		input word_t rx_len, output header_result_t r);
		idx_t pos;
		err_t err;
		r = '0;
		pos = first ? idx_t'(0) : pos_now;
		if (pos == idx_t'(0)) begin
			lrc_sum = b;
			marker_seen = (b == MARKER[0]);
		end else begin
			lrc_sum = lrc_sum + b;
			if (pos < IDX_ID)
				marker_seen = marker_seen && (b == MARKER[pos]);
		end
		if (pos == IDX_ID)
			cap_id = b;
		else if (pos == IDX_SOURCE)
			cap_src = b;
		else if (pos == IDX_FLAGS)
			cap_flags = b;
		else if (pos >= IDX_PLEN_LO && pos < IDX_BCNT_LO)
			cap_plen[8*int'(pos - IDX_PLEN_LO) +: 8] = b;
		else if (pos >= IDX_BCNT_LO)
			cap_bcnt[8*int'(pos - IDX_BCNT_LO) +: 8] = b;
		if (pos != IDX_LAST) begin
			pos_now = pos + 1'b1;
			return 1'b0;
		end

		err = E_NONE;
		err[ERR_MARKER]  = !marker_seen;
		err[ERR_ID]      = (cap_id >= lim.pkt_limit && cap_id < lim.fire_layer) ||
			cap_id >= lim.stream_limit;
		err[ERR_SOURCE]  = (cap_src >= lim.onboard_limit && cap_src < lim.server_base) ||
			cap_src >= lim.remote_limit;
		err[ERR_LRC]     = lrc_sum != 8'hFF;
		err[ERR_FLAGS]   = (cap_flags & ~lim.flag_mask) != 8'h00;
		err[ERR_PAYLOAD] = cap_id <= lim.pkt_limit && cap_plen > lim.max_payload;
		err[ERR_LENGTH]  = ({1'b0, cap_plen} + 33'(HDR_BYTES)) != {1'b0, rx_len};

		r.ok    = (err == E_NONE);
		r.err   = err;
		r.id    = cap_id;
		r.src   = cap_src;
		r.flags = cap_flags;
		r.plen  = cap_plen;
		r.bcnt  = cap_bcnt;
		pos_now = '0;
		lrc_sum = '0;
		marker_seen = 1'b1;
		return 1'b1;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int unsigned pick_gap(bit enabled);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// present one header beat, hold it until accepted, then predict
	task automatic send_beat(byte_t b, logic first, word_t rx_len, bit pinned,
		header_result_t pin);
		int unsigned    gap;
		header_result_t r;
		gap = pick_gap(tx_idle);
		if (gap > 0) begin
			hdr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hdr_ch.valid           <= 1'b1;
		hdr_ch.header_byte     <= b;
		hdr_ch.first_byte      <= first;
		hdr_ch.received_length <= rx_len;
		do @(posedge clk); while (!hdr_ch.ready);
		if (fold_header_byte(b, first, rx_len, r))
			pending_verdicts.push_back(pinned ? pin : r);
	endtask

	// lay out the header bytes, fix up the LRC, then send the planned prefix
	task automatic send_header(hdr_plan_t pl);
		byte_t          hb [HDR_BYTES];
		byte_t          sum;
		header_result_t pin;
		int             i;
		for (i = 0; i < HDR_BYTES; i++)
			hb[i] = '0;
		for (i = 0; i < 4; i++) begin
			hb[i] = MARKER[i];
			hb[int'(IDX_PLEN_LO) + i] = pl.plen[8*i +: 8];
			hb[int'(IDX_BCNT_LO) + i] = pl.bcnt[8*i +: 8];
		end
		hb[pl.mark_pos]   = hb[pl.mark_pos] ^ pl.marker_flip;
		hb[IDX_ID]        = pl.id;
		hb[IDX_SOURCE]    = pl.src;
		hb[IDX_FLAGS]     = pl.flags;
		sum = '0;
		for (i = 0; i < HDR_BYTES; i++)
			sum = sum + hb[i];
		hb[LRC_POS] = 8'hFF - sum + pl.lrc_skew;

		pin.ok    = (pl.err == E_NONE);
		pin.err   = pl.err;
		pin.id    = pl.id;
		pin.src   = pl.src;
		pin.flags = pl.flags;
		pin.plen  = pl.plen;
		pin.bcnt  = pl.bcnt;
		for (i = 0; i < int'(pl.n_bytes); i++)
			send_beat(hb[i], (i == 0) && pl.first_mark,
				(i == int'(IDX_LAST)) ? pl.rx_len : word_t'($urandom),
				pl.pinned && (i == int'(IDX_LAST)), pin);
	endtask

	// pick a byte near one of three range edges, or anywhere
	function automatic byte_t near_edge(byte_t a, byte_t b, byte_t c);
		int unsigned r;
		byte_t       e;
		r = $urandom_range(0, 3);
		if (r == 3)
			return byte_t'($urandom);
		e = (r == 0) ? a : (r == 1) ? b : c;
		return e + byte_t'($urandom_range(0, 2)) - 8'd1;
	endfunction

	function automatic word_t pick_payload();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return lim.max_payload + word_t'($urandom_range(0, 2)) - 32'd1;
		if (r < 8)
			return word_t'($urandom_range(0, 4096));
		return word_t'($urandom);
	endfunction

	// mostly well-formed headers with random content; some broken, some noise
	task automatic send_random_header();
		hdr_plan_t   pl;
		int unsigned kind;
		int unsigned r;
		kind = $urandom_range(0, 99);
		if (kind >= 90)
			repeat ($urandom_range(1, 8))
				send_beat(byte_t'($urandom), logic'($urandom_range(0, 1)),
					word_t'($urandom), 1'b0, '0);
		pl.id    = near_edge(lim.pkt_limit, lim.fire_layer, lim.stream_limit);
		pl.src   = near_edge(lim.onboard_limit, lim.server_base, lim.remote_limit);
		pl.flags = ($urandom_range(0, 3) == 0) ? byte_t'($urandom) :
			byte_t'($urandom) & lim.flag_mask;
		pl.plen  = pick_payload();
		pl.bcnt  = $urandom;
		r = $urandom_range(0, 9);
		if (r == 0)
			pl.rx_len = $urandom;
		else if (r == 1)
			pl.rx_len = pl.plen + 32'd16 + word_t'($urandom_range(0, 2)) - 32'd1;
		else
			pl.rx_len = pl.plen + 32'd16;
		pl.lrc_skew    = ($urandom_range(0, 9) == 0) ? byte_t'($urandom_range(1, 255)) : '0;
		pl.marker_flip = ($urandom_range(0, 11) == 0) ? byte_t'($urandom_range(1, 255)) : '0;
		pl.mark_pos    = 2'($urandom_range(0, 3));
		pl.first_mark  = ($urandom_range(0, 6) != 0);
		pl.n_bytes     = (kind < 10) ? 5'($urandom_range(1, 15)) : 5'(HDR_BYTES);
		pl.pinned      = 1'b0;
		pl.err         = E_NONE;
		send_header(pl);
	endtask

	// drop valid and advance so the next beat starts on a fresh edge
	task automatic idle_sender();
		hdr_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_results_drained();
		idle_sender();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t data);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata     <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		unique case (idx)
			REG_PID_PACKET_LIMIT:  lim.pkt_limit     = data[7:0];
			REG_PID_FIRE_LAYER:    lim.fire_layer    = data[7:0];
			REG_PID_STREAM_LIMIT:  lim.stream_limit  = data[7:0];
			REG_SRC_ONBOARD_LIMIT: lim.onboard_limit = data[7:0];
			REG_SRC_SERVER_BASE:   lim.server_base   = data[7:0];
			REG_SRC_REMOTE_LIMIT:  lim.remote_limit  = data[7:0];
			REG_VALID_FLAGS_MASK:  lim.flag_mask     = data[7:0];
			REG_MAX_PAYLOAD_LEN:   lim.max_payload   = data;
			default: ;
		endcase
	endtask

	// byte registers get junk in the unused upper bits
	function automatic word_t pad_byte(byte_t v);
		return {24'($urandom), v};
	endfunction

	task automatic load_limits(check_limits_t s);
		write_reg(REG_PID_PACKET_LIMIT,  pad_byte(s.pkt_limit));
		write_reg(REG_PID_FIRE_LAYER,    pad_byte(s.fire_layer));
		write_reg(REG_PID_STREAM_LIMIT,  pad_byte(s.stream_limit));
		write_reg(REG_SRC_ONBOARD_LIMIT, pad_byte(s.onboard_limit));
		write_reg(REG_SRC_SERVER_BASE,   pad_byte(s.server_base));
		write_reg(REG_SRC_REMOTE_LIMIT,  pad_byte(s.remote_limit));
		write_reg(REG_VALID_FLAGS_MASK,  pad_byte(s.flag_mask));
		write_reg(REG_MAX_PAYLOAD_LEN,   s.max_payload);
		cfg_ch.valid <= 1'b0;
	endtask

	// zeros, ones, reset values, then random limits
	function automatic check_limits_t pick_limits(int unsigned p);
		check_limits_t s;
		unique case (p)
			0: s = '0;
			1: s = '1;
			2: s = '{RST_PID_PACKET_LIMIT, RST_PID_FIRE_LAYER, RST_PID_STREAM_LIMIT,
				RST_SRC_ONBOARD_LIMIT, RST_SRC_SERVER_BASE, RST_SRC_REMOTE_LIMIT,
				RST_VALID_FLAGS_MASK, RST_MAX_PAYLOAD_LEN};
			default: begin
				s.pkt_limit     = byte_t'($urandom);
				s.fire_layer    = byte_t'($urandom);
				s.stream_limit  = byte_t'($urandom);
				s.onboard_limit = byte_t'($urandom);
				s.server_base   = byte_t'($urandom);
				s.remote_limit  = byte_t'($urandom);
				s.flag_mask     = byte_t'($urandom);
				s.max_payload   = (p == NUM_PHASES - 1) ? word_t'($urandom) :
					word_t'($urandom_range(0, 'hFFFF));
			end
		endcase
		return s;
	endfunction

	// result receiver: bursts of ready with random stalls
	initial begin : result_sink
		int unsigned stall;
		res_ch.ready = 1'b1;
		forever begin
			repeat ($urandom_range(1, 12)) @(posedge clk);
			stall = pick_gap(rx_idle);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				res_ch.ready <= 1'b1;
			end
		end
	end

	// compare each result beat with the oldest predicted verdict
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none pending",
					results_seen));
			end else begin
				want = pending_verdicts.pop_front();
				check_field("header_ok",   res_ch.header_ok,   want.ok);
				check_field("error_bits",  res_ch.error_bits,  want.err);
				check_field("packet_id",   res_ch.packet_id,   want.id);
				check_field("source_id",   res_ch.source_id,   want.src);
				check_field("flag_bits",   res_ch.flag_bits,   want.flags);
				check_field("payload_len", res_ch.payload_len, want.plen);
				check_field("block_count", res_ch.block_count, want.bcnt);
			end
			results_seen++;
		end
	end

	// stop a hung run: too many cycles with no beat on any channel
	always @(posedge clk) begin
		if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL packet_header_checker");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned p;
		int unsigned k;
		arst_n                 = 1'b0;
		hdr_ch.valid           = 1'b0;
		hdr_ch.header_byte     = '0;
		hdr_ch.first_byte      = 1'b0;
		hdr_ch.received_length = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.reg_index       = REG_PID_PACKET_LIMIT;
		cfg_ch.wdata           = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table under reset limits
		for (k = 0; k < NUM_DIRECTED; k++)
			send_header(directed_plan[k]);

		// random phases, each under new limits written while idle
		for (p = 0; p < NUM_PHASES; p++) begin
			wait_results_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			load_limits(pick_limits(p));
			tx_idle = (p != 2);
			rx_idle = (p != 2);
			for (k = 0; k < HDRS_PER_PHASE; k++) begin
				send_random_header();
				if (p == 3 && k == 3)
					wait_results_drained();
			end
		end

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS packet_header_checker");
		else
			$display("FAIL packet_header_checker");
		$finish;
	end

endmodule

// File: files.f
sv/phc_pkg.sv
sv/phc_if.sv
sv/packet_header_checker.sv
sv/phc_checker.sv
dv/testbench.sv
